@@ design/implicit_binary_tree_lookup_assert.svh @@
// Assertion macros used by the tree lookup module.
`ifndef IMPLICIT_BINARY_TREE_LOOKUP_ASSERT_SVH
`define IMPLICIT_BINARY_TREE_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define IBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tree lookup: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define IBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tree lookup: next-cycle check failed");

`endif

@@ design/ibt_pkg.sv @@
// Shared types and constants of the implicit binary tree lookup.
`timescale 1ns / 1ps
package ibt_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  en;
        t_word data;
    } t_wr_cmd;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_NEIGH = 4'b0100,
        ST_HOLD  = 4'b1000
    } t_state;

    localparam logic       OP_WRITE     = 1'b0;
    localparam logic       OP_QUERY     = 1'b1;
    localparam logic [3:0] HEIGHT_RESET = 4'd8;

endpackage

@@ design/ibt_cell.sv @@
// One slot of the rotating node ring.
`timescale 1ns / 1ps
module ibt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  ibt_pkg::t_word i_data,
    input  ibt_pkg::t_word i_next,
    output ibt_pkg::t_word o_value
);
    import ibt_pkg::*;

    t_word r_value;
    t_word n_value;

    // take the write word, else pass the neighbour's slot along
    always_comb begin
        n_value = i_load ? i_data : i_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

@@ design/ibt_ring.sv @@
// Ring of node cells that rotates one slot towards the head every cycle.
`timescale 1ns / 1ps
module ibt_ring #(
    parameter int IW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ibt_pkg::t_wr_cmd i_wr,
    input  logic [IW-1:0]    i_wr_slot,
    output ibt_pkg::t_word   o_head,
    output logic [IW-1:0]    o_head_idx
);
    import ibt_pkg::*;

    localparam int DEPTH = 1 << IW;

    logic [IW-1:0] r_base;
    logic [IW-1:0] n_base;
    logic [IW-1:0] w_target;
    t_word         w_val [DEPTH];

    // cell k holds slot base+k; after this edge the slot sits one cell lower
    always_comb begin
        n_base   = r_base + IW'(1);
        w_target = i_wr_slot - r_base - IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else begin
            r_base <= n_base;
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        ibt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (i_wr.en && (w_target == IW'(k))),
            .i_data  (i_wr.data),
            .i_next  (w_val[(k + 1) % DEPTH]),
            .o_value (w_val[k])
        );
    end

    assign o_head     = w_val[0];
    assign o_head_idx = r_base;

endmodule

@@ design/implicit_binary_tree_lookup.sv @@
// Queries: the input stalls from acceptance until the result is loaded into the output register,
// so no new query or write is accepted while a query is in progress.
// The node ring turns one slot per cycle: one turn finds the lowest matching index,
// a second turn picks up the parent, children and sibling as they pass the head.
// A write does not stall the input, so the next word is accepted straight after it.
// Reset (synchronous, active low) empties every slot at once and sets the height to 8.
`timescale 1ns / 1ps
`include "implicit_binary_tree_lookup_assert.svh"
module implicit_binary_tree_lookup #(
    parameter int MAX_HEIGHT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_position,
    input  logic signed [31:0] i_node_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [7:0]  o_node_index,
    output logic        o_parent_present,
    output logic signed [31:0] o_parent_value,
    output logic        o_left_present,
    output logic signed [31:0] o_left_value,
    output logic        o_right_present,
    output logic signed [31:0] o_right_value,
    output logic        o_sibling_present,
    output logic signed [31:0] o_sibling_value
);
    import ibt_pkg::*;

    localparam int IW = MAX_HEIGHT;
    localparam int CW = (IW > 8) ? IW + 2 : 10;

    t_state        r_state;
    t_state        n_state;
    logic [3:0]    r_height;
    logic [IW-1:0] r_step;
    logic          r_found;
    logic [IW-1:0] r_hit;
    t_word         r_key;
    t_word         r_par;
    t_word         r_lft;
    t_word         r_rgt;
    t_word         r_sib;
    logic          r_out_valid;
    logic          r_out_found;
    logic [7:0]    r_out_idx;
    t_word         r_out_par;
    t_word         r_out_lft;
    t_word         r_out_rgt;
    t_word         r_out_sib;

    logic [4:0]    w_height;
    logic [CW-1:0] w_limit;
    logic          w_acc;
    logic          w_query;
    t_wr_cmd       w_wr;
    t_word         w_head;
    logic [IW-1:0] w_head_idx;
    logic [CW-1:0] w_idx_c;
    logic [CW-1:0] w_hit_c;
    logic          w_in_range;
    logic          w_match;
    logic          w_not_root;
    logic          w_load;
    logic          w_last;

    always_comb begin
        w_height = {1'b0, r_height};
        if (w_height < 5'd1) begin
            w_height = 5'd1;
        end
        if (w_height > 5'(MAX_HEIGHT)) begin
            w_height = 5'(MAX_HEIGHT);
        end
        w_limit = CW'(1) << w_height;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_query     = w_acc && (i_opcode == OP_QUERY);

    // drop writes to the root's parent slot and beyond the tree
    always_comb begin
        w_wr.en   = w_acc && (i_opcode == OP_WRITE) && (i_position != 8'd0)
                    && (CW'(i_position) < w_limit);
        w_wr.data = i_node_value;
    end

    ibt_ring #(
        .IW (IW)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_wr_slot  (IW'(i_position)),
        .o_head     (w_head),
        .o_head_idx (w_head_idx)
    );

    always_comb begin
        w_idx_c    = CW'(w_head_idx);
        w_hit_c    = CW'(r_hit);
        w_in_range = (w_idx_c < w_limit);
        w_match    = w_in_range && (w_head_idx != '0) && (r_key != '0) && (w_head == r_key);
        w_not_root = r_found && (r_hit != IW'(1));
        w_last     = (r_step == '1);
        w_load     = (r_state == ST_HOLD) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_last) begin
                    n_state = ST_NEIGH;
                end
            end
            ST_NEIGH: begin
                if (w_last) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_height    <= HEIGHT_RESET;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_height <= i_cfg_data;
            end
            if (w_query) begin
                r_step  <= '0;
                r_found <= 1'b0;
            end else if (r_state == ST_SCAN || r_state == ST_NEIGH) begin
                r_step <= r_step + IW'(1);
            end
            if (r_state == ST_SCAN && w_match) begin
                r_found <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: search key, lowest hit and the neighbour words seen at the head
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_key <= i_node_value;
            r_hit <= '0;
            r_par <= '0;
            r_lft <= '0;
            r_rgt <= '0;
            r_sib <= '0;
        end
        if (r_state == ST_SCAN && w_match && (!r_found || w_head_idx < r_hit)) begin
            r_hit <= w_head_idx;
        end
        if (r_state == ST_NEIGH && w_in_range) begin
            if (w_not_root && w_idx_c == (w_hit_c >> 1)) begin
                r_par <= w_head;
            end
            if (r_found && w_idx_c == (w_hit_c << 1)) begin
                r_lft <= w_head;
            end
            if (r_found && w_idx_c == ((w_hit_c << 1) | CW'(1))) begin
                r_rgt <= w_head;
            end
            if (w_not_root && w_idx_c == (w_hit_c ^ CW'(1))) begin
                r_sib <= w_head;
            end
        end
        if (w_load) begin
            r_out_found <= r_found;
            r_out_idx   <= r_found ? 8'(r_hit) : 8'd0;
            r_out_par   <= r_par;
            r_out_lft   <= r_lft;
            r_out_rgt   <= r_rgt;
            r_out_sib   <= r_sib;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_found           = r_out_found;
    assign o_node_index      = r_out_idx;
    assign o_parent_present  = (r_out_par != '0);
    assign o_parent_value    = r_out_par;
    assign o_left_present    = (r_out_lft != '0);
    assign o_left_value      = r_out_lft;
    assign o_right_present   = (r_out_rgt != '0);
    assign o_right_value     = r_out_rgt;
    assign o_sibling_present = (r_out_sib != '0);
    assign o_sibling_value   = r_out_sib;

    `IBT_ASSERT_IMP(a_hit_not_zero, i_clk, i_rst_n, r_found, r_hit != '0)
    `IBT_ASSERT_NXT(a_scan_full_turn, i_clk, i_rst_n, (r_state == ST_SCAN) && !w_last, r_state == ST_SCAN)
    `IBT_ASSERT_IMP(a_miss_is_blank, i_clk, i_rst_n, o_out_valid && !o_found, (o_node_index == 8'd0) && !o_parent_present && !o_left_present && !o_right_present && !o_sibling_present)

endmodule

@@ test/implicit_binary_tree_lookup_tb.sv @@
// Self-checking testbench for the implicit binary tree lookup block.
`timescale 1ns / 1ps
module implicit_binary_tree_lookup_tb;
    import ibt_pkg::*;

    localparam int TREE_MAX_HEIGHT = 8;
    localparam int SLOT_COUNT      = 1 << TREE_MAX_HEIGHT;
    localparam int SETTLE_CYCLES   = 2 * SLOT_COUNT + 8;
    localparam int LONG_HOLD       = 1200;
    localparam int PHASES          = 9;

    typedef struct packed {
        logic       found;
        logic [7:0] node_idx;
        logic       parent_ok;
        t_word      parent_val;
        logic       left_ok;
        t_word      left_val;
        logic       right_ok;
        t_word      right_val;
        logic       sib_ok;
        t_word      sib_val;
    } t_lookup_result;

    // Keeps a private copy of the tree and the lookups still owed by the block.
    class lookup_scoreboard;
        t_word          slots [SLOT_COUNT];
        logic [3:0]     height;
        t_lookup_result lookups_owed [$];
        int             mismatches;
        int             stores;
        int             lookups;
        int             hits;

        function new();
            foreach (slots[k]) slots[k] = '0;
            height     = HEIGHT_RESET;
            mismatches = 0;
            stores     = 0;
            lookups    = 0;
            hits       = 0;
        endfunction

        function int unsigned slot_limit();
            int unsigned h;
            h = height;
            if (h < 1) h = 1;
            if (h > TREE_MAX_HEIGHT) h = TREE_MAX_HEIGHT;
            return 1 << h;
        endfunction

        function t_word slot_at(int unsigned idx, int unsigned lim, bit ok);
            return (ok && idx < lim) ? slots[idx] : '0;
        endfunction

        function void note_word(logic op, logic [7:0] pos, t_word val);
            int unsigned    lim;
            int unsigned    hit;
            t_lookup_result r;
            lim = slot_limit();
            if (op == OP_WRITE) begin
                stores++;
                if (pos != 0 && pos < lim) slots[pos] = val;
                return;
            end
            lookups++;
            r   = '0;
            hit = 0;
            if (val != '0) begin
                for (int unsigned i = 1; i < lim; i++) begin
                    if (slots[i] == val) begin
                        hit = i;
                        break;
                    end
                end
            end
            if (hit != 0) begin
                hits++;
                r.found      = 1'b1;
                r.node_idx   = hit[7:0];
                r.parent_val = slot_at(hit >> 1, lim, hit != 1);
                r.left_val   = slot_at(hit << 1, lim, 1'b1);
                r.right_val  = slot_at((hit << 1) | 1, lim, 1'b1);
                r.sib_val    = slot_at(hit ^ 1, lim, hit != 1);
                r.parent_ok  = r.parent_val != '0;
                r.left_ok    = r.left_val != '0;
                r.right_ok   = r.right_val != '0;
                r.sib_ok     = r.sib_val != '0;
            end
            lookups_owed.push_back(r);
        endfunction

        task report_mismatch(string what, t_word got, t_word want);
            mismatches++;
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        endtask

        task check_result(t_lookup_result got);
            t_lookup_result want;
            if (lookups_owed.size() == 0) begin
                report_mismatch("result with no lookup owed", t_word'(got.node_idx), '0);
                return;
            end
            want = lookups_owed.pop_front();
            if (got.found !== want.found)
                report_mismatch("found", t_word'(got.found), t_word'(want.found));
            if (got.node_idx !== want.node_idx)
                report_mismatch("node index", t_word'(got.node_idx), t_word'(want.node_idx));
            if (got.parent_ok !== want.parent_ok)
                report_mismatch("parent present", t_word'(got.parent_ok), t_word'(want.parent_ok));
            if (got.parent_val !== want.parent_val)
                report_mismatch("parent value", got.parent_val, want.parent_val);
            if (got.left_ok !== want.left_ok)
                report_mismatch("left present", t_word'(got.left_ok), t_word'(want.left_ok));
            if (got.left_val !== want.left_val)
                report_mismatch("left value", got.left_val, want.left_val);
            if (got.right_ok !== want.right_ok)
                report_mismatch("right present", t_word'(got.right_ok), t_word'(want.right_ok));
            if (got.right_val !== want.right_val)
                report_mismatch("right value", got.right_val, want.right_val);
            if (got.sib_ok !== want.sib_ok)
                report_mismatch("sibling present", t_word'(got.sib_ok), t_word'(want.sib_ok));
            if (got.sib_val !== want.sib_val)
                report_mismatch("sibling value", got.sib_val, want.sib_val);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_opcode = OP_WRITE;
    logic [7:0]  in_position = '0;
    t_word       in_value = '0;
    logic        cfg_valid = 1'b0;
    logic [3:0]  cfg_data = '0;
    logic        out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_cfg_ready;
    logic        o_out_valid;
    logic        o_found;
    logic [7:0]  o_node_index;
    logic        o_parent_present;
    logic [31:0] o_parent_value;
    logic        o_left_present;
    logic [31:0] o_left_value;
    logic        o_right_present;
    logic [31:0] o_right_value;
    logic        o_sibling_present;
    logic [31:0] o_sibling_value;

    lookup_scoreboard sb = new();

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    results_taken = 0;
    int    hold_left     = 0;
    bit    hold_done     = 1'b0;
    t_word value_pool [8];
    logic [3:0] phase_height [PHASES] = '{4'd8, 4'd3, 4'd1, 4'd0, 4'd15, 4'd5, 4'd8, 4'd2, 4'd7};

    implicit_binary_tree_lookup i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (in_opcode),
        .i_position        (in_position),
        .i_node_value      (in_value),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_found           (o_found),
        .o_node_index      (o_node_index),
        .o_parent_present  (o_parent_present),
        .o_parent_value    (o_parent_value),
        .o_left_present    (o_left_present),
        .o_left_value      (o_left_value),
        .o_right_present   (o_right_present),
        .o_right_value     (o_right_value),
        .o_sibling_present (o_sibling_present),
        .o_sibling_value   (o_sibling_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiving side: check each accepted word, then choose the next stall.
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            sb.check_result('{o_found, o_node_index, o_parent_present, o_parent_value,
                              o_left_present, o_left_value, o_right_present, o_right_value,
                              o_sibling_present, o_sibling_value});
            results_taken <= results_taken + 1;
        end
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_taken == 20) begin
            // hold off long enough for the block to back up onto its input
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_word(logic op, logic [7:0] pos, t_word val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        in_opcode   <= op;
        in_position <= pos;
        in_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(op, pos, val);
    endtask

    task automatic wait_lookups_done();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.lookups_owed.size() != 0);
    endtask

    task automatic write_height(logic [3:0] h);
        cfg_valid <= 1'b1;
        cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sb.height = h;
    endtask

    task automatic run_directed();
        send_word(OP_QUERY, 8'd0,   32'd5);          // empty tree
        send_word(OP_QUERY, 8'd0,   32'd0);          // zero is never found
        send_word(OP_WRITE, 8'd0,   32'd77);         // position zero is dropped
        send_word(OP_QUERY, 8'd255, 32'd77);
        send_word(OP_WRITE, 8'd1,   32'h7fff_ffff);
        send_word(OP_WRITE, 8'd2,   32'h8000_0000);
        send_word(OP_WRITE, 8'd3,   32'hffff_ffff);
        send_word(OP_WRITE, 8'd255, 32'h8000_0000);
        send_word(OP_WRITE, 8'd127, 32'd11);
        send_word(OP_WRITE, 8'd254, 32'd22);
        send_word(OP_WRITE, 8'd128, 32'd33);
        send_word(OP_QUERY, 8'd0,   32'h7fff_ffff);  // root: no parent, no sibling
        send_word(OP_QUERY, 8'd0,   32'h8000_0000);  // duplicate: lowest index wins
        send_word(OP_WRITE, 8'd2,   32'd0);          // empty the slot again
        send_word(OP_QUERY, 8'd0,   32'h8000_0000);  // last leaf, children beyond the tree
        send_word(OP_QUERY, 8'd0,   32'hffff_ffff);
        send_word(OP_QUERY, 8'd0,   32'd11);
        send_word(OP_QUERY, 8'd0,   32'd33);
        send_word(OP_QUERY, 8'd0,   32'd12345);
    endtask

    task automatic run_random(int count, bit pause_mid);
        int unsigned lim;
        int unsigned roll;
        int unsigned pick;
        logic [7:0]  pos;
        t_word       val;
        for (int n = 0; n < count; n++) begin
            if (pause_mid && n == count / 2)
                wait_lookups_done();
            lim  = sb.slot_limit();
            roll = $urandom_range(99);
            pick = $urandom_range(99);
            if (roll < 58) begin
                pos = (roll < 50) ? 8'($urandom_range(lim - 1, 1)) : 8'($urandom_range(255, 0));
                if (pick < 65)
                    val = value_pool[$urandom_range(7, 0)];
                else if (pick < 75)
                    val = '0;
                else
                    val = t_word'($urandom);
                send_word(OP_WRITE, pos, val);
            end else begin
                pos = 8'($urandom_range(255, 0));
                if (pick < 55)
                    val = sb.slots[$urandom_range(lim - 1, 1)];
                else if (pick < 80)
                    val = value_pool[$urandom_range(7, 0)];
                else if (pick < 93)
                    val = t_word'($urandom);
                else
                    val = '0;
                send_word(OP_QUERY, pos, val);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                wait_lookups_done();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                write_height(phase_height[p]);
            end
            send_idle_pct  = (p < 3) ? 12 : (p < 6) ? 56 : 0;
            recv_idle_pct <= (p < 3) ? 56 : (p < 6) ? 12 : 0;
            value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd1,
                           t_word'($urandom_range(9, 2)), t_word'($urandom),
                           t_word'($urandom), t_word'($urandom)};
            if (p == 0)
                run_directed();
            run_random((p == 0) ? 240 : 195, p == 4);
        end
        wait_lookups_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d lookups (%0d matched) and %0d stores over %0d height settings,",
                 sb.lookups, sb.hits, sb.stores, PHASES);
        $display("with heights 0 and 15 clamped, one long output hold and a mid-run drain.");
        if (sb.mismatches == 0 && sb.lookups_owed.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
